// File: rtl/roi_detection_filter_dwell_assert.svh
// assertion macros for the roi detection filter with dwell tracking
// used by roi_detection_filter_dwell; expects clk and rst_n in scope
`ifndef ROI_DETECTION_FILTER_DWELL_ASSERT_SVH
`define ROI_DETECTION_FILTER_DWELL_ASSERT_SVH

// same-cycle implication
`define RDFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RDFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rdfd_pkg.sv
// types and constants for the roi detection filter with dwell tracking
// no dependencies
package rdfd_pkg;

    localparam int BOX_W = 14;
    localparam int TS_W = 48;
    localparam int CLS_W = 8;
    localparam int SLOT_W = 2;
    localparam int REG_SLOTS = 4;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_FRAME_W = 3'd2;
    localparam logic [2:0] REG_FRAME_H = 3'd3;
    localparam logic [2:0] REG_REGION0 = 3'd4;
    localparam logic [2:0] REG_REGION1 = 3'd5;
    localparam logic [2:0] REG_REGION2 = 3'd6;
    localparam logic [2:0] REG_REGION3 = 3'd7;

    typedef struct packed {
        logic signed [BOX_W-1:0] bottom;
        logic signed [BOX_W-1:0] right;
        logic signed [BOX_W-1:0] top;
        logic signed [BOX_W-1:0] left;
    } box_t;

    typedef struct packed {
        logic live;
        logic [TS_W-1:0] start;
        box_t box;
    } trk_entry_t;

endpackage

// File: rtl/roi_detection_filter_dwell.sv
// roi detection filter with per region and class dwell tracking, top level
// depends on rdfd_pkg and roi_detection_filter_dwell_assert.svh
//
// channel | direction | handshake            | payload
// in      | sink      | in_valid / in_stall  | box edges, object_class, timestamp_ms
// out     | source    | out_valid / out_stall| keep, in_region, region_slot, dwell
// cfg     | sink      | apb psel / penable   | 64-bit registers at 8*index
//
// one item per cycle unless in_stall is high, result passes each stage into the output register
// stages: region match and table read, overlap products, restart and dwell
// track table is one memory, one write and one registered read per cycle
// after reset a clearing pass over every track entry holds in_stall
// a stalled output holds its item while up to three more items enter
`include "roi_detection_filter_dwell_assert.svh"

module roi_detection_filter_dwell #(
    parameter int NUM_REGIONS = 4,
    parameter int NUM_CLASSES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rdfd_pkg::ADDR_W-1:0]       paddr,
    input  logic [rdfd_pkg::DATA_W-1:0]       pwdata,
    output logic [rdfd_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [rdfd_pkg::BOX_W-1:0] box_left,
    input  logic signed [rdfd_pkg::BOX_W-1:0] box_top,
    input  logic signed [rdfd_pkg::BOX_W-1:0] box_right,
    input  logic signed [rdfd_pkg::BOX_W-1:0] box_bottom,
    input  logic [rdfd_pkg::CLS_W-1:0]        object_class,
    input  logic [rdfd_pkg::TS_W-1:0]         timestamp_ms,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              keep,
    output logic                              in_region,
    output logic [rdfd_pkg::SLOT_W-1:0]       region_slot,
    output logic                              dwell_event,
    output logic [31:0]                       dwell_ms
);
    import rdfd_pkg::*;

    localparam int NREG = (NUM_REGIONS > REG_SLOTS) ? REG_SLOTS : NUM_REGIONS;
    localparam int DEPTH = NREG * NUM_CLASSES;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // configuration
    logic [1:0]  mode_reg;
    logic [31:0] thr_reg;
    logic [12:0] fw_reg;
    logic [12:0] fh_reg;
    logic [63:0] region_reg [REG_SLOTS];
    logic        cfg_wr;

    // scaled region bounds
    logic [29:0] bx1_reg [NREG];
    logic [29:0] bx2_reg [NREG];
    logic [29:0] by1_reg [NREG];
    logic [29:0] by2_reg [NREG];
    logic        rvalid_reg [NREG];

    // clearing pass
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    // stage 1
    logic             s1_valid_reg;
    box_t             s1_box_reg;
    logic [CLS_W-1:0] s1_cls_reg;
    logic [TS_W-1:0]  s1_ts_reg;
    logic             s1_adv;
    logic             s1_keep;
    logic             s1_inreg;
    logic [SLOT_W-1:0] s1_slot;
    logic             s1_track;
    logic [IDX_W-1:0] s1_idx;

    // stage 2
    logic              s2_valid_reg;
    box_t              s2_box_reg;
    logic [TS_W-1:0]   s2_ts_reg;
    logic              s2_track_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic              s2_keep_reg;
    logic              s2_inreg_reg;
    logic [SLOT_W-1:0] s2_slot_reg;
    logic              s2_byp_reg;
    trk_entry_t        s2_byp_data_reg;
    trk_entry_t        rd_data_reg;
    logic              s2_adv;
    trk_entry_t        s2_entry;
    logic              s2_fwd;
    logic              s2_live;
    box_t              s2_old;
    logic [27:0]       s2_inter;
    logic [27:0]       s2_aa;
    logic [27:0]       s2_ea;

    // stage 3
    logic              s3_valid_reg;
    box_t              s3_box_reg;
    logic [TS_W-1:0]   s3_ts_reg;
    logic              s3_track_reg;
    logic [IDX_W-1:0]  s3_idx_reg;
    logic              s3_keep_reg;
    logic              s3_inreg_reg;
    logic [SLOT_W-1:0] s3_slot_reg;
    logic              s3_live_reg;
    logic              s3_fwd_reg;
    logic [TS_W-1:0]   s3_start_reg;
    logic [27:0]       s3_inter_reg;
    logic [27:0]       s3_aa_reg;
    logic [27:0]       s3_ea_reg;
    logic              s3_adv;
    logic              s3_restart;
    logic [TS_W-1:0]   s3_new_start;
    logic              s3_event;
    logic [31:0]       s3_dwell;
    logic [TS_W-1:0]   last_start_reg;

    // output
    logic              out_valid_reg;
    logic              keep_reg;
    logic              in_region_reg;
    logic [SLOT_W-1:0] region_slot_reg;
    logic              dwell_event_reg;
    logic [31:0]       dwell_ms_reg;

    // track memory
    trk_entry_t mem [DEPTH];
    logic       wr_en;
    trk_entry_t wr_data;

    function automatic logic [13:0] span(input logic signed [13:0] lo,
                                         input logic signed [13:0] hi);
        logic signed [14:0] d;
        d = 15'(hi) - 15'(lo);
        return d[14] ? 14'd0 : d[13:0];
    endfunction

    function automatic logic signed [13:0] smax(input logic signed [13:0] a,
                                                input logic signed [13:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [13:0] smin(input logic signed [13:0] a,
                                                input logic signed [13:0] b);
        return (a < b) ? a : b;
    endfunction

    // ---------------- configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            thr_reg <= '0;
            fw_reg <= 13'd640;
            fh_reg <= 13'd480;
            for (int i = 0; i < REG_SLOTS; i++)
            begin
                region_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            case (paddr[5:3])
                REG_MODE:      mode_reg <= pwdata[1:0];
                REG_THRESHOLD: thr_reg <= pwdata[31:0];
                REG_FRAME_W:   fw_reg <= pwdata[12:0];
                REG_FRAME_H:   fh_reg <= pwdata[12:0];
                REG_REGION0:   region_reg[0] <= pwdata;
                REG_REGION1:   region_reg[1] <= pwdata;
                REG_REGION2:   region_reg[2] <= pwdata;
                REG_REGION3:   region_reg[3] <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_MODE:      prdata = 64'(mode_reg);
            REG_THRESHOLD: prdata = 64'(thr_reg);
            REG_FRAME_W:   prdata = 64'(fw_reg);
            REG_FRAME_H:   prdata = 64'(fh_reg);
            REG_REGION0:   prdata = region_reg[0];
            REG_REGION1:   prdata = region_reg[1];
            REG_REGION2:   prdata = region_reg[2];
            REG_REGION3:   prdata = region_reg[3];
            default:       prdata = '0;
        endcase
    end

    // ---------------- region bounds scaled to the frame
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NREG; i++)
        begin
            logic [15:0] x1;
            logic [15:0] y1;
            logic [15:0] x2;
            logic [15:0] y2;
            logic [16:0] sx2;
            logic [16:0] sy2;
            x1 = (region_reg[i][15:0] > ONE_Q15) ? ONE_Q15 : region_reg[i][15:0];
            y1 = (region_reg[i][31:16] > ONE_Q15) ? ONE_Q15 : region_reg[i][31:16];
            sx2 = 17'(region_reg[i][15:0]) + 17'(region_reg[i][47:32]);
            sy2 = 17'(region_reg[i][31:16]) + 17'(region_reg[i][63:48]);
            x2 = (sx2 > 17'(ONE_Q15)) ? ONE_Q15 : sx2[15:0];
            y2 = (sy2 > 17'(ONE_Q15)) ? ONE_Q15 : sy2[15:0];
            rvalid_reg[i] <= (x2 > x1) && (y2 > y1);
            bx1_reg[i] <= {29'(x1) * 29'(fw_reg), 1'b0};
            bx2_reg[i] <= {29'(x2) * 29'(fw_reg), 1'b0};
            by1_reg[i] <= {29'(y1) * 29'(fh_reg), 1'b0};
            by2_reg[i] <= {29'(y2) * 29'(fh_reg), 1'b0};
        end
    end

    // ---------------- handshake and stage advance
    assign s3_adv = s3_valid_reg && (!out_valid_reg || !out_stall);
    assign s2_adv = s2_valid_reg && (!s3_valid_reg || s3_adv);
    assign s1_adv = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign in_stall = clr_busy_reg || (s1_valid_reg && !s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST_IDX)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ---------------- stage 1: region match
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_box_reg <= '{bottom: box_bottom, right: box_right, top: box_top, left: box_left};
            s1_cls_reg <= object_class;
            s1_ts_reg <= timestamp_ms;
        end
    end

    always_comb
    begin
        logic signed [14:0] sum_x;
        logic signed [14:0] sum_y;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               any_valid;
        logic               found;
        logic [SLOT_W-1:0]  fidx;
        logic [31:0]        idx_full;
        sum_x = 15'(s1_box_reg.left) + 15'(s1_box_reg.right);
        sum_y = 15'(s1_box_reg.top) + 15'(s1_box_reg.bottom);
        sx = {{2{sum_x[14]}}, sum_x, 15'd0};
        sy = {{2{sum_y[14]}}, sum_y, 15'd0};
        any_valid = 1'b0;
        found = 1'b0;
        fidx = '0;
        for (int i = NREG - 1; i >= 0; i--)
        begin
            if (rvalid_reg[i])
            begin
                any_valid = 1'b1;
                if (sx >= $signed({2'b00, bx1_reg[i]}) && sx <= $signed({2'b00, bx2_reg[i]})
                    && sy >= $signed({2'b00, by1_reg[i]})
                    && sy <= $signed({2'b00, by2_reg[i]}))
                begin
                    found = 1'b1;
                    fidx = SLOT_W'(i);
                end
            end
        end
        s1_keep = 1'b1;
        s1_inreg = 1'b0;
        s1_slot = '0;
        s1_track = 1'b0;
        if (mode_reg[0] && any_valid)
        begin
            if (found)
            begin
                s1_inreg = 1'b1;
                s1_slot = fidx;
                s1_track = (thr_reg != 32'd0) && (32'(s1_cls_reg) < NUM_CLASSES);
            end
            else
            begin
                s1_keep = !mode_reg[1];
            end
        end
        idx_full = 32'(fidx) * NUM_CLASSES + 32'(s1_cls_reg);
        s1_idx = s1_track ? idx_full[IDX_W-1:0] : '0;
    end

    // ---------------- track memory
    assign wr_en = s3_adv && s3_track_reg;
    assign wr_data = '{live: 1'b1, start: s3_new_start, box: s3_box_reg};

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[s3_idx_reg] <= wr_data;
        end
        if (s1_adv)
        begin
            rd_data_reg <= mem[s1_idx];
        end
    end

    // ---------------- stage 2: overlap areas
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_box_reg <= s1_box_reg;
            s2_ts_reg <= s1_ts_reg;
            s2_track_reg <= s1_track;
            s2_idx_reg <= s1_idx;
            s2_keep_reg <= s1_keep;
            s2_inreg_reg <= s1_inreg;
            s2_slot_reg <= s1_slot;
            s2_byp_reg <= wr_en && (s3_idx_reg == s1_idx);
            s2_byp_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        logic [13:0] iw;
        logic [13:0] ih;
        s2_entry = s2_byp_reg ? s2_byp_data_reg : rd_data_reg;
        s2_fwd = s3_valid_reg && s3_track_reg && (s3_idx_reg == s2_idx_reg);
        s2_live = s2_fwd || s2_entry.live;
        s2_old = s2_fwd ? s3_box_reg : s2_entry.box;
        iw = span(smax(s2_old.left, s2_box_reg.left), smin(s2_old.right, s2_box_reg.right));
        ih = span(smax(s2_old.top, s2_box_reg.top), smin(s2_old.bottom, s2_box_reg.bottom));
        s2_inter = 28'(iw) * 28'(ih);
        s2_aa = 28'(span(s2_old.left, s2_old.right)) * 28'(span(s2_old.top, s2_old.bottom));
        s2_ea = 28'(span(s2_box_reg.left, s2_box_reg.right))
              * 28'(span(s2_box_reg.top, s2_box_reg.bottom));
    end

    // ---------------- stage 3: restart and dwell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s3_valid_reg <= 1'b1;
        end
        else if (s3_adv)
        begin
            s3_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s3_box_reg <= s2_box_reg;
            s3_ts_reg <= s2_ts_reg;
            s3_track_reg <= s2_track_reg;
            s3_idx_reg <= s2_idx_reg;
            s3_keep_reg <= s2_keep_reg;
            s3_inreg_reg <= s2_inreg_reg;
            s3_slot_reg <= s2_slot_reg;
            s3_live_reg <= s2_live;
            s3_fwd_reg <= s2_fwd;
            s3_start_reg <= s2_entry.start;
            s3_inter_reg <= s2_inter;
            s3_aa_reg <= s2_aa;
            s3_ea_reg <= s2_ea;
        end
        if (wr_en)
        begin
            last_start_reg <= s3_new_start;
        end
    end

    always_comb
    begin
        logic signed [31:0] uni;
        logic [30:0]        inter5;
        logic [TS_W-1:0]    old_start;
        logic [TS_W-1:0]    elapsed;
        uni = $signed(32'(s3_aa_reg) + 32'(s3_ea_reg) - 32'(s3_inter_reg));
        inter5 = (31'(s3_inter_reg) << 2) + 31'(s3_inter_reg);
        s3_restart = !s3_live_reg || (uni <= 0) || ($signed({1'b0, inter5}) < uni);
        old_start = s3_fwd_reg ? last_start_reg : s3_start_reg;
        s3_new_start = s3_restart ? s3_ts_reg : old_start;
        elapsed = (s3_ts_reg >= s3_new_start) ? (s3_ts_reg - s3_new_start) : '0;
        s3_event = s3_track_reg && (elapsed >= TS_W'(thr_reg));
        if (!s3_track_reg)
        begin
            s3_dwell = '0;
        end
        else if (|elapsed[TS_W-1:32])
        begin
            s3_dwell = '1;
        end
        else
        begin
            s3_dwell = elapsed[31:0];
        end
    end

    // ---------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            keep_reg <= s3_keep_reg;
            in_region_reg <= s3_inreg_reg;
            region_slot_reg <= s3_slot_reg;
            dwell_event_reg <= s3_event;
            dwell_ms_reg <= s3_dwell;
        end
    end

    assign out_valid = out_valid_reg;
    assign keep = keep_reg;
    assign in_region = in_region_reg;
    assign region_slot = region_slot_reg;
    assign dwell_event = dwell_event_reg;
    assign dwell_ms = dwell_ms_reg;

    // ---------------- assertions
    `RDFD_ASSERT_NOW(a_clear_empty, clr_busy_reg,
        !s1_valid_reg && !s2_valid_reg && !s3_valid_reg, "item in flight during clear")
    `RDFD_ASSERT_NEXT(a_result_lands, s3_adv, out_valid_reg, "stage 3 result lost")
    `RDFD_ASSERT_NEXT(a_restart_start, wr_en && s3_restart,
        last_start_reg == $past(s3_ts_reg), "restart did not take timestamp")
    `RDFD_ASSERT_NOW(a_event_inside, out_valid_reg && dwell_event_reg,
        in_region_reg && keep_reg, "dwell event outside region")
    `RDFD_ASSERT_NOW(a_slot_zero, out_valid_reg && !in_region_reg,
        region_slot_reg == '0 && dwell_ms_reg == '0, "slot or dwell set outside region")

endmodule
